// ----- design/pid_with_windup_and_deadzone_core_defines.svh -----
// Assertion macros shared by the PID core RTL.
// Needs nothing else; the bodies compile away when SYNTHESIS is defined.
`ifndef PID_WITH_WINDUP_AND_DEADZONE_CORE_DEFINES_SVH
`define PID_WITH_WINDUP_AND_DEADZONE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PWDZ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwdz: same-cycle check failed");
`define PWDZ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwdz: next-cycle check failed");
`else
`define PWDZ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PWDZ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/pwdz_pkg.sv -----
// Shared types and constants of the PID core.
// Used by pwdz_mul and the top level of the block; depends on nothing.
package pwdz_pkg;

   localparam int DATA_W     = 16;  // Q8.8 error, setpoint and gains
   localparam int GAIN_W     = 16;
   localparam int OUT_W      = 24;  // Q16.8 drive and limits
   localparam int LIM_W      = 23;  // unsigned caps
   localparam int FRAC_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_FEED_FWD     = 3'd3,
      CSR_OUT_UPPER    = 3'd4,
      CSR_OUT_LOWER    = 3'd5,
      CSR_INTEG_CAP    = 3'd6,
      CSR_WINDUP_LIMIT = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_DSTART,
      S_DIV,
      S_FF,
      S_P,
      S_D,
      S_I,
      S_W,
      S_OUT
   } state_type;

endpackage

// ----- design/pwdz_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the integral ring of the PID core.
module pwdz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pwdz_mul.sv -----
// Shared signed gain multiplier with a floor shift back to Q.8 and a registered result.
// Depends on pwdz_pkg.
module pwdz_mul import pwdz_pkg::*; #(
   parameter int OPB_W = 24
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [GAIN_W-1:0]                op_a,
   input  logic signed [OPB_W-1:0]                 op_b,
   output logic signed [GAIN_W+OPB_W-FRAC_W-1:0]   res
);

   logic signed [GAIN_W+OPB_W-1:0]        prod;
   logic signed [GAIN_W+OPB_W-FRAC_W-1:0] res_ff;

   // Dropping the low fraction bits of a two's complement product rounds
   // toward minus infinity.
   assign prod = op_a * op_b;

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= $signed(prod[GAIN_W+OPB_W-1:FRAC_W]);
      end
   end

   assign res = res_ff;

endmodule

// ----- design/pwdz_div.sv -----
// Division by a constant through a reciprocal multiplication.
// Standalone; the quotient is registered and valid in the cycle after start.
module pwdz_div #(
   parameter int DW      = 18,
   parameter int DIVISOR = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   output logic          done,
   output logic [DW-1:0] quotient
);

   // With SH = DW + clog2(DIVISOR) and RECIP = ceil(2**SH / DIVISOR), the top
   // bits of dividend * RECIP equal floor(dividend / DIVISOR) for every
   // DW-bit dividend, so one multiply replaces the divide.
   localparam int SH = DW + $clog2(DIVISOR);
   localparam int MW = DW + 2;
   localparam int PW = SH + DW;
   localparam longint RECIP_L = ((longint'(1) << SH) + longint'(DIVISOR) - 1)
                                / longint'(DIVISOR);
   localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

   logic [PW-1:0] prod;
   logic [DW-1:0] quo_ff;
   logic          done_ff;

   assign prod = PW'(dividend) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= prod[PW-1:SH];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/pid_with_windup_and_deadzone_core.sv -----
// Top level of the PID core with integral anti-windup, dead zone and feed-forward.
// Depends on pwdz_pkg, pwdz_ram, pwdz_mul, pwdz_div and the assertion macro header.
`include "pid_with_windup_and_deadzone_core_defines.svh"

// One error/setpoint sample in, one clamped Q16.8 drive value out. The core
// takes a sample only from its idle state and then works on it alone: when
// any entry of the error history is zero the sample skips the history sum
// and the divide; otherwise the history is summed one entry per cycle and
// the sum is divided by ERROR_HIST_LEN through a registered reciprocal
// multiplication. The four gain products then share one registered
// multiplier. A finished result sits in an output register, so the next
// sample can be taken while it waits for its transfer; only when that
// register is still full and stalled does the core wait in its last step.
// The integral ring lives in a RAM with one valid bit per entry and a
// running sum, so clearing it (on a setpoint change or on windup) only
// resets the valid bits and the sum, and needs no sweep after reset. Gain
// and limit registers may only be written while the core is idle.
module pid_with_windup_and_deadzone_core import pwdz_pkg::*; #(
   parameter int ERROR_HIST_LEN  = 4,
   parameter int INTEG_HIST_LEN  = 16,
   parameter int DEAD_ZONE       = 16,
   parameter int RESET_ON_TARGET = 1,
   parameter int ALWAYS_INTEG    = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   // Sample channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_W-1:0]     req_error_in,
   input  logic signed [DATA_W-1:0]     req_set_point,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_drive_out,
   // Register write port
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // History sum, ring sum, gain product and drive accumulator widths.
   localparam int HSW    = DATA_W + $clog2(ERROR_HIST_LEN);
   localparam int RSW    = DATA_W + $clog2(INTEG_HIST_LEN);
   localparam int IW     = GAIN_W + RSW - FRAC_W;
   localparam int ACC_W  = IW + 2;
   localparam int HIDX_W = (ERROR_HIST_LEN > 1) ? $clog2(ERROR_HIST_LEN) : 1;
   localparam int PTR_W  = (INTEG_HIST_LEN > 1) ? $clog2(INTEG_HIST_LEN) : 1;
   localparam logic signed [DATA_W:0] DZ_HI = (DATA_W+1)'(DEAD_ZONE);
   localparam logic signed [DATA_W:0] DZ_LO = -DZ_HI;

   // Configuration registers.
   logic signed [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, feed_fwd_gain_ff;
   logic signed [OUT_W-1:0]  out_upper_ff, out_lower_ff;
   logic [LIM_W-1:0]         integ_cap_ff, windup_limit_ff;

   // Sequencer and datapath state.
   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] hist_ff [ERROR_HIST_LEN];
   logic signed [DATA_W-1:0] last_target_ff;
   logic signed [DATA_W-1:0] err_ff, sp_ff;
   logic [HIDX_W-1:0]        hidx_ff, hidx_in;
   logic signed [HSW-1:0]    hsum_ff, hsum_in;
   logic signed [DATA_W-1:0] avg_ff, avg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [OUT_W-1:0]  p_ff, p_in;
   logic                     wrote_ff, wrote_in;
   logic [PTR_W-1:0]         ring_ptr_ff, ring_ptr_in;
   logic [INTEG_HIST_LEN-1:0] ring_valid_ff, ring_valid_in;
   logic signed [RSW-1:0]    ring_sum_ff, ring_sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_drive_ff, rsp_drive_in;

   // Combinational helpers.
   logic                     req_accept;
   logic                     tgt_change;
   logic                     any_zero;
   logic signed [DATA_W-1:0] newest;
   logic signed [DATA_W:0]   newest_ext;
   logic                     dz_out;
   logic signed [DATA_W-1:0] old_entry;
   logic [PTR_W-1:0]         ptr_next;
   logic signed [OUT_W-1:0]  p_raw, p_upper, p_clamped;
   logic [OUT_W-1:0]         p_mag;
   logic signed [IW-1:0]     i_val;
   logic [IW-1:0]            i_mag;
   logic                     d_en;
   logic                     wind_clear;
   logic signed [DATA_W-1:0] q_mag;
   logic signed [ACC_W-1:0]  upper_ext, lower_ext;
   logic signed [OUT_W-1:0]  drive_clamped;

   // Shared units.
   logic                     mul_en;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [RSW-1:0]    mul_b;
   logic signed [IW-1:0]     mul_res;
   logic                     div_start, div_done;
   logic [HSW-1:0]           div_quo;
   logic                     ram_we, ram_re;
   logic [DATA_W-1:0]        ram_rdata;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign tgt_change = (RESET_ON_TARGET != 0) && (req_set_point != last_target_ff);

   // Register writes; codes outside the list do not exist with a 3-bit index.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integ_gain_ff    <= '0;
         deriv_gain_ff    <= '0;
         feed_fwd_gain_ff <= '0;
         out_upper_ff     <= '0;
         out_lower_ff     <= '0;
         integ_cap_ff     <= '0;
         windup_limit_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:    prop_gain_ff     <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INTEG_GAIN:   integ_gain_ff    <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_DERIV_GAIN:   deriv_gain_ff    <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_FEED_FWD:     feed_fwd_gain_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_OUT_UPPER:    out_upper_ff     <= $signed(csr_wdata[OUT_W-1:0]);
            CSR_OUT_LOWER:    out_lower_ff     <= $signed(csr_wdata[OUT_W-1:0]);
            CSR_INTEG_CAP:    integ_cap_ff     <= csr_wdata[LIM_W-1:0];
            CSR_WINDUP_LIMIT: windup_limit_ff  <= csr_wdata[LIM_W-1:0];
            default:          prop_gain_ff     <= prop_gain_ff;
         endcase
      end
   end

   // Error history: the new error shifts in at entry 0 on a transfer that keeps
   // the setpoint; with RESET_ON_TARGET set, the whole history is wiped when it moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ERROR_HIST_LEN; k++) begin
            hist_ff[k] <= '0;
         end
         last_target_ff <= '0;
      end else if (req_accept) begin
         if (tgt_change) begin
            for (int k = 0; k < ERROR_HIST_LEN; k++) begin
               hist_ff[k] <= '0;
            end
            last_target_ff <= req_set_point;
         end else begin
            for (int k = ERROR_HIST_LEN - 1; k > 0; k--) begin
               hist_ff[k] <= hist_ff[k-1];
            end
            hist_ff[0] <= req_error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         err_ff <= req_error_in;
         sp_ff  <= req_set_point;
      end
   end

   // A zero anywhere in the history makes the average fall back to the raw error.
   always_comb begin
      any_zero = 1'b0;
      for (int k = 0; k < ERROR_HIST_LEN; k++) begin
         any_zero = any_zero | (hist_ff[k] == '0);
      end
   end

   // Dead zone test on the newest history entry; after a setpoint change it
   // is zero and never enters the ring.
   assign newest     = hist_ff[0];
   assign newest_ext = (DATA_W+1)'(newest);
   assign dz_out     = (newest_ext > DZ_HI) || (newest_ext < DZ_LO);
   assign old_entry  = ring_valid_ff[ring_ptr_ff] ? $signed(ram_rdata) : '0;
   assign ptr_next   = (ring_ptr_ff == PTR_W'(INTEG_HIST_LEN - 1)) ? '0
                                                                  : ring_ptr_ff + 1'b1;

   // P clamp tests the upper bound first and then the lower, so with crossed
   // limits a large P still lands on the lower bound.
   assign p_raw     = $signed(mul_res[OUT_W-1:0]);
   assign p_upper   = (p_raw > out_upper_ff) ? out_upper_ff : p_raw;
   assign p_clamped = (p_upper < out_lower_ff) ? out_lower_ff : p_upper;
   assign p_mag     = p_ff[OUT_W-1] ? OUT_W'(-p_ff) : OUT_W'(p_ff);
   assign d_en      = (p_mag < OUT_W'(windup_limit_ff));

   // The integral term only counts when the ring took a sample this tick,
   // unless it is configured to act every tick.
   assign i_val      = ((ALWAYS_INTEG != 0) || wrote_ff) ? mul_res : '0;
   assign i_mag      = i_val[IW-1] ? IW'(-i_val) : IW'(i_val);
   assign wind_clear = (i_mag > IW'(integ_cap_ff)) || (p_mag > OUT_W'(windup_limit_ff));

   assign q_mag = $signed(div_quo[DATA_W-1:0]);

   // Drive clamp: the lower bound is only tested when the upper one passes.
   assign upper_ext     = ACC_W'(out_upper_ff);
   assign lower_ext     = ACC_W'(out_lower_ff);
   assign drive_clamped = (acc_ff > upper_ext) ? out_upper_ff
                        : (acc_ff < lower_ext) ? out_lower_ff
                        : $signed(acc_ff[OUT_W-1:0]);

   // Sequencer: history sum and divide unless the history holds a zero,
   // then one gain product per cycle through the shared multiplier, each
   // folded into the drive accumulator (P via p_ff, I unless windup).
   always_comb begin
      state_in      = state_ff;
      hidx_in       = hidx_ff;
      hsum_in       = hsum_ff;
      avg_in        = avg_ff;
      acc_in        = acc_ff;
      p_in          = p_ff;
      wrote_in      = wrote_ff;
      ring_ptr_in   = ring_ptr_ff;
      ring_valid_in = ring_valid_ff;
      ring_sum_in   = ring_sum_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_drive_in  = rsp_drive_ff;
      div_start     = 1'b0;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_SUM;
               hidx_in  = '0;
               hsum_in  = '0;
               if (tgt_change) begin
                  ring_valid_in = '0;
                  ring_sum_in   = '0;
               end
            end
         end
         S_SUM: begin
            if (any_zero) begin
               avg_in   = err_ff;
               state_in = S_FF;
            end else begin
               hsum_in = hsum_ff + HSW'(hist_ff[hidx_ff]);
               hidx_in = hidx_ff + 1'b1;
               if (hidx_ff == HIDX_W'(ERROR_HIST_LEN - 1)) begin
                  state_in = S_DSTART;
               end
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               // Divide the magnitude and put the sign back: truncation toward zero.
               avg_in   = hsum_ff[HSW-1] ? -q_mag : q_mag;
               state_in = S_FF;
            end
         end
         S_FF: begin
            mul_en   = 1'b1;
            mul_a    = feed_fwd_gain_ff;
            mul_b    = RSW'(sp_ff);
            ram_re   = 1'b1;
            state_in = S_P;
         end
         S_P: begin
            acc_in   = ACC_W'(mul_res);
            mul_en   = 1'b1;
            mul_a    = prop_gain_ff;
            mul_b    = RSW'(avg_ff);
            wrote_in = dz_out;
            if (dz_out) begin
               ram_we                     = 1'b1;
               ring_valid_in[ring_ptr_ff] = 1'b1;
               ring_sum_in = ring_sum_ff - RSW'(old_entry) + RSW'(newest);
               ring_ptr_in = ptr_next;
            end
            state_in = S_D;
         end
         S_D: begin
            p_in     = p_clamped;
            mul_en   = 1'b1;
            mul_a    = deriv_gain_ff;
            mul_b    = RSW'(avg_ff);
            state_in = S_I;
         end
         S_I: begin
            acc_in   = acc_ff + ACC_W'(p_ff) + (d_en ? ACC_W'(mul_res) : '0);
            mul_en   = 1'b1;
            mul_a    = integ_gain_ff;
            mul_b    = ring_sum_ff;
            state_in = S_W;
         end
         S_W: begin
            if (wind_clear) begin
               ring_valid_in = '0;
               ring_sum_in   = '0;
            end else begin
               acc_in = acc_ff + ACC_W'(i_val);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_clamped;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ring_ptr_ff   <= '0;
         ring_valid_ff <= '0;
         ring_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         wrote_ff      <= 1'b0;
         hidx_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         ring_ptr_ff   <= ring_ptr_in;
         ring_valid_ff <= ring_valid_in;
         ring_sum_ff   <= ring_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         wrote_ff      <= wrote_in;
         hidx_ff       <= hidx_in;
      end
   end

   always_ff @(posedge clock) begin
      hsum_ff      <= hsum_in;
      avg_ff       <= avg_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_ff;

   pwdz_mul #(
      .OPB_W (RSW)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   pwdz_div #(
      .DW      (HSW),
      .DIVISOR (ERROR_HIST_LEN)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hsum_ff[HSW-1] ? HSW'(-hsum_ff) : HSW'(hsum_ff)),
      .done     (div_done),
      .quotient (div_quo)
   );

   pwdz_ram #(
      .WIDTH (DATA_W),
      .DEPTH (INTEG_HIST_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ring_ptr_ff),
      .wr_data (newest),
      .rd_en   (ram_re),
      .rd_addr (ring_ptr_ff),
      .rd_data (ram_rdata)
   );

   // The core goes busy right after it takes a sample.
   `PWDZ_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // An empty ring must have a zero running sum.
   `PWDZ_ASSERT_IMPL(a_empty_ring_sum, clock, reset, ring_valid_ff == '0, ring_sum_ff == '0)
   // The ring write pointer stays inside the ring.
   `PWDZ_ASSERT_IMPL(a_ptr_range, clock, reset, 1'b1, ring_ptr_ff <= PTR_W'(INTEG_HIST_LEN - 1))
   // A new result only appears out of the final sequencer step.
   `PWDZ_ASSERT_NEXT(a_result_source, clock, reset, !rsp_valid_ff, !rsp_valid_ff || $past(state_ff) == S_OUT)

endmodule

// ----- tb/tb_pid_with_windup_and_deadzone_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the PID core with anti-windup, dead zone and feed-forward.
// Depends on pwdz_pkg and pid_with_windup_and_deadzone_core; a built-in model predicts each drive.
module tb_pid_with_windup_and_deadzone_core;
   import pwdz_pkg::*;

   // Build of the core under test; the model below is written for these values.
   localparam int HIST_LEN  = 4;
   localparam int RING_LEN  = 16;
   localparam int DEAD_BAND = 16;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   // A long receiver hold-off, well beyond the time of one sample, so that the
   // core finishes one sample, parks it in its output register, takes another
   // and then has to stall its sample channel.
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 64;
   localparam int PHASE_ITEMS  = 200;
   localparam int N_PHASES     = 7;
   // Slowest correct run is about 1425 samples, each with its core work plus
   // any sender gap and receiver stall.
   localparam int CYCLE_LIMIT  = 500000;

   // Predicts the drive value of every sample that the core takes and holds
   // the drives that are still due, oldest first.
   class pid_drive_model;
      logic signed [GAIN_W-1:0] kp, ki, kd, kff;
      logic signed [OUT_W-1:0]  lim_hi, lim_lo;
      logic [LIM_W-1:0]         icap, wlim;
      logic signed [DATA_W-1:0] hist [HIST_LEN];
      logic signed [DATA_W-1:0] ring [RING_LEN];
      int unsigned              wr_ptr;
      logic signed [DATA_W-1:0] last_sp;
      logic signed [OUT_W-1:0]  drive_due [$];
      int                       fails;

      function new();
         kp = '0; ki = '0; kd = '0; kff = '0;
         lim_hi = '0; lim_lo = '0; icap = '0; wlim = '0;
         foreach (hist[k]) hist[k] = '0;
         foreach (ring[k]) ring[k] = '0;
         wr_ptr = 0;
         last_sp = '0;
         fails = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_PROP_GAIN:    kp     = v[GAIN_W-1:0];
            CSR_INTEG_GAIN:   ki     = v[GAIN_W-1:0];
            CSR_DERIV_GAIN:   kd     = v[GAIN_W-1:0];
            CSR_FEED_FWD:     kff    = v[GAIN_W-1:0];
            CSR_OUT_UPPER:    lim_hi = v[OUT_W-1:0];
            CSR_OUT_LOWER:    lim_lo = v[OUT_W-1:0];
            CSR_INTEG_CAP:    icap   = v[LIM_W-1:0];
            CSR_WINDUP_LIMIT: wlim   = v[LIM_W-1:0];
            default: ;
         endcase
      endfunction

      // Q16.16 product back to Q16.8, rounding toward minus infinity.
      static function longint q8_floor(longint x);
         return x >>> FRAC_W;
      endfunction

      static function longint magnitude(longint x);
         return (x < 0) ? -x : x;
      endfunction

      function void take_sample(logic signed [DATA_W-1:0] err, logic signed [DATA_W-1:0] sp);
         longint avg, p, i_term, d, ff, acc, drive;
         bit     any_zero, wrote;
         for (int k = HIST_LEN - 1; k > 0; k--)
            hist[k] = hist[k-1];
         hist[0] = err;

         // A new setpoint restarts the loop: history and integral are both dropped.
         if (sp != last_sp) begin
            foreach (hist[k]) hist[k] = '0;
            foreach (ring[k]) ring[k] = '0;
            last_sp = sp;
         end

         ff = q8_floor(longint'(kff) * longint'(sp));

         // The mean is used only once the history holds no zero entry.
         acc = 0;
         any_zero = 1'b0;
         foreach (hist[k]) begin
            if (!any_zero) begin
               if (hist[k] == 0)
                  any_zero = 1'b1;
               else
                  acc += longint'(hist[k]);
            end
         end
         avg = any_zero ? longint'(err) : acc / HIST_LEN;

         p = q8_floor(longint'(kp) * avg);
         if (p > longint'(lim_hi))
            p = longint'(lim_hi);
         if (p < longint'(lim_lo))
            p = longint'(lim_lo);

         wrote = 1'b0;
         if (hist[0] > DEAD_BAND || hist[0] < -DEAD_BAND) begin
            ring[wr_ptr] = hist[0];
            wr_ptr = (wr_ptr + 1) % RING_LEN;
            wrote = 1'b1;
         end

         acc = 0;
         foreach (ring[k]) acc += longint'(ring[k]);
         i_term = 0;
         if (wrote)
            i_term = q8_floor(longint'(ki) * acc);

         if (magnitude(i_term) > longint'(icap) || magnitude(p) > longint'(wlim)) begin
            foreach (ring[k]) ring[k] = '0;
            i_term = 0;
         end

         d = 0;
         if (magnitude(p) < longint'(wlim))
            d = q8_floor(longint'(kd) * avg);

         drive = p + i_term + d + ff;
         if (drive > longint'(lim_hi))
            drive = longint'(lim_hi);
         else if (drive < longint'(lim_lo))
            drive = longint'(lim_lo);
         drive_due.push_back(drive[OUT_W-1:0]);
      endfunction

      function void check_drive(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (drive_due.size() == 0) begin
            fails++;
            $display("%0t: unexpected drive, expected none, actual %0d", $time, got);
         end else begin
            want = drive_due.pop_front();
            if (got !== want) begin
               fails++;
               $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction

      function int pending();
         return drive_due.size();
      endfunction
   endclass

   // Every input of the core starts at a known value.
   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_error_in  = '0;
   logic signed [DATA_W-1:0] req_set_point = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic signed [OUT_W-1:0]  rsp_drive_out;
   logic                     csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata     = '0;

   bit calm     = 1'b0;   // no idling on either side
   bit hold_rsp = 1'b0;   // request for one long receiver hold-off
   int stall_left = 0;
   int cycle_count = 0;

   pid_drive_model model = new();

   pid_with_windup_and_deadzone_core #(
      .ERROR_HIST_LEN  (HIST_LEN),
      .INTEG_HIST_LEN  (RING_LEN),
      .DEAD_ZONE       (DEAD_BAND),
      .RESET_ON_TARGET (1),
      .ALWAYS_INTEG    (0)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_error_in  (req_error_in),
      .req_set_point (req_set_point),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive_out (rsp_drive_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off that this process
   // counts out itself while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_rsp) begin
         stall_left = HOLD_CYCLES;
         hold_rsp = 1'b0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // A drive is transferred at an edge where valid is high and stall is low;
   // both are sampled here before anything driven at this edge takes effect.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.check_drive(rsp_drive_out);
   end

   // One register write per clock; the caller lowers the write enable after a batch.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      model.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Writes all eight registers. Bits above a register's width carry random
   // junk, since the core is expected to ignore them.
   task automatic load_regs(logic signed [GAIN_W-1:0] kp, logic signed [GAIN_W-1:0] ki,
                            logic signed [GAIN_W-1:0] kd, logic signed [GAIN_W-1:0] kff,
                            logic signed [OUT_W-1:0] hi, logic signed [OUT_W-1:0] lo,
                            logic [LIM_W-1:0] cap, logic [LIM_W-1:0] wl);
      write_reg(CSR_PROP_GAIN,    {8'($urandom), kp});
      write_reg(CSR_INTEG_GAIN,   {8'($urandom), ki});
      write_reg(CSR_DERIV_GAIN,   {8'($urandom), kd});
      write_reg(CSR_FEED_FWD,     {8'($urandom), kff});
      write_reg(CSR_OUT_UPPER,    hi);
      write_reg(CSR_OUT_LOWER,    lo);
      write_reg(CSR_INTEG_CAP,    {1'($urandom), cap});
      write_reg(CSR_WINDUP_LIMIT, {1'($urandom), wl});
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 3))
         0:       return GAIN_W'($urandom);
         1:       return GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
         default: return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic logic signed [OUT_W-1:0] rand_limit();
      case ($urandom_range(0, 3))
         0:       return OUT_W'($urandom);
         1:       return OUT_W'(int'($urandom_range(0, 200000)) - 100000);
         2:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         default: return OUT_W'(int'($urandom_range(0, 20000)) - 10000);
      endcase
   endfunction

   function automatic logic [LIM_W-1:0] rand_cap();
      case ($urandom_range(0, 3))
         0:       return LIM_W'($urandom);
         1:       return LIM_W'($urandom_range(0, 2000));
         2:       return $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
         default: return LIM_W'($urandom_range(0, 200000));
      endcase
   endfunction

   // Random registers; with crossed set the lower limit ends at or above the upper one.
   task automatic random_regs(bit crossed);
      logic signed [OUT_W-1:0] a, b, hi, lo;
      a = rand_limit();
      b = rand_limit();
      hi = (a >= b) ? a : b;
      lo = (a >= b) ? b : a;
      if (crossed)
         load_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(), lo, hi,
                   rand_cap(), rand_cap());
      else
         load_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(), hi, lo,
                   rand_cap(), rand_cap());
   endtask

   function automatic logic signed [DATA_W-1:0] rand_error();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return DATA_W'(int'($urandom_range(0, 40)) - 20);
         3:       return DATA_W'($urandom);
         4: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0001;
               default: return 16'shFFFF;
            endcase
         end
         default: return DATA_W'(int'($urandom_range(1, 3000)) *
                                 ($urandom_range(0, 1) ? 1 : -1));
      endcase
   endfunction

   // Offers one sample and returns at the edge of its transfer, valid still high.
   task automatic send_sample(logic signed [DATA_W-1:0] err, logic signed [DATA_W-1:0] sp);
      req_valid     <= 1'b1;
      req_error_in  <= err;
      req_set_point <= sp;
      do
         @(posedge clock);
      while (req_stall);
      model.take_sample(err, sp);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Sender pauses until every predicted drive has been transferred; the core
   // is idle then, so registers may be written.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0)
         @(posedge clock);
   endtask

   // Mostly runs of a steady setpoint, so that the history fills and the mean,
   // the dead zone, the ring and the windup logic all come into play. Now and
   // then a stray setpoint breaks a run and clears everything.
   task automatic run_random(int n);
      logic signed [DATA_W-1:0] sp, err;
      int run_left, i;
      sp = '0;
      run_left = 0;
      for (i = 0; i < n; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(3, 40);
            case ($urandom_range(0, 4))
               0, 1:    sp = DATA_W'(int'($urandom_range(0, 1024)) - 512);
               2:       sp = DATA_W'($urandom);
               default: ;
            endcase
         end
         run_left--;
         err = rand_error();
         if (!calm && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 5));
         if ($urandom_range(0, 19) == 0)
            send_sample(err, DATA_W'($urandom));
         else
            send_sample(err, sp);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: every term is zero, so is every drive.
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'sh7FFF, 16'sh0000);
      send_sample(16'sh8000, 16'sh0000);
      wait_drained();

      // Moderate gains. The first sample changes the setpoint and clears the
      // history, then the dead zone is probed at both signs on and past its
      // edge, and four equal errors make the mean take over from the raw error.
      load_regs(16'sh0100, 16'sh0040, 16'sh0020, 16'sh0080,
                24'sd100000, -24'sd100000, 23'd50000, 23'd40000);
      send_sample(16'sd300, 16'sh0100);
      send_sample(16'sd16, 16'sh0100);
      send_sample(16'sd17, 16'sh0100);
      send_sample(-16'sd16, 16'sh0100);
      send_sample(-16'sd17, 16'sh0100);
      repeat (4) send_sample(16'sd500, 16'sh0100);
      send_sample(16'sh7FFF, 16'sh0100);
      send_sample(16'sh8000, 16'sh0100);
      wait_drained();

      // Largest gains, widest limits, zero windup limit: any nonzero P clears the
      // integral, and D stays out.
      load_regs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'h0);
      repeat (4) send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000);
      wait_drained();

      // Most negative gains, crossed limits and a zero integral cap.
      load_regs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                -24'sd1000, 24'sd1000, 23'h0, 23'h7FFFFF);
      send_sample(16'sd1000, 16'sh0040);
      send_sample(-16'sd1000, 16'sh0040);
      send_sample(16'sd0, 16'sh0040);
      send_sample(16'sd20, 16'sh0040);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: load_regs(16'sh0180, 16'sh0020, 16'sh0040, 16'sh0100,
                         24'sd200000, -24'sd200000, 23'd80000, 23'd60000);
            2: load_regs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                         24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF);
            3: random_regs(1'b1);
            5: load_regs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                         24'sh7FFFFF, 24'sh800000, 23'h0, 23'h0);
            default: random_regs(1'b0);
         endcase
         calm = (ph == N_PHASES - 1);
         if (ph == 1)
            hold_rsp = 1'b1;
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      // Give a stray drive time to show up after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (model.fails == 0 && model.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
